FILE: rtl/calibrated_level_scaler_unit_assert.svh
// Assertion macros used by the checker file of the level scaler.
`ifndef CALIBRATED_LEVEL_SCALER_UNIT_ASSERT_SVH
`define CALIBRATED_LEVEL_SCALER_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CLS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("level scaler check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define CLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("level scaler check failed");

`endif

FILE: rtl/cls_pkg.sv
// Types and constants shared by the calibrated level scaler modules.
package cls_pkg;

  localparam int unsigned CountW     = 32;
  localparam int unsigned LevelShift = 10;
  localparam int unsigned LevelW     = LevelShift + 1;
  localparam int unsigned NumCells   = LevelW;
  localparam int unsigned RemW       = CountW + 1;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [CountW-1:0] ErasedValue = {CountW{1'b1}};
  localparam logic [CountW-1:0] MinSpan     = CountW'(100);

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_CAL_ERR    = 2'd1,
    STATUS_SENSOR_ERR = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DRY_COUNT = 1'b0,
    REG_WET_COUNT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic              valid;
    status_e           status;
    logic [RemW-1:0]   rem;
    logic [CountW-1:0] span;
    logic [LevelW-1:0] quo;
  } stage_t;

endpackage

FILE: rtl/cls_front.sv
// Input stage: calibration check, count clamp and divider operand setup.
module cls_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [cls_pkg::CountW-1:0] count_i,
  input  logic [cls_pkg::CountW-1:0] dry_i,
  input  logic [cls_pkg::CountW-1:0] wet_i,
  output cls_pkg::stage_t           out_o
);
  import cls_pkg::*;

  logic              valid_q;
  stage_t            pay_d, pay_q;
  logic              cal_ok;
  logic [CountW-1:0] span;
  logic [CountW-1:0] clamped;

  assign span   = dry_i - wet_i;
  assign cal_ok = (dry_i != ErasedValue) && (wet_i != ErasedValue) &&
                  (dry_i >= wet_i) && (span >= MinSpan);

  always_comb begin
    clamped = count_i;
    if (count_i < wet_i) begin
      clamped = wet_i;
    end
    if (count_i > dry_i) begin
      clamped = dry_i;
    end
  end

  always_comb begin
    pay_d.valid = valid_i;
    pay_d.rem   = {1'b0, clamped - wet_i};
    pay_d.span  = span;
    pay_d.quo   = '0;
    priority if (!cal_ok) begin
      pay_d.status = STATUS_CAL_ERR;
    end else if (count_i == '0) begin
      pay_d.status = STATUS_SENSOR_ERR;
    end else begin
      pay_d.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= pay_d;
    end
  end

  always_comb begin
    out_o       = pay_q;
    out_o.valid = valid_q;
  end

endmodule

FILE: rtl/cls_div_cell.sv
// One restoring division cell: yields one quotient bit and the next partial remainder.
module cls_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  cls_pkg::stage_t in_i,
  output cls_pkg::stage_t out_o
);
  import cls_pkg::*;

  logic            valid_q;
  stage_t          pay_d, pay_q;
  logic            ge;
  logic [RemW-1:0] diff;

  assign ge   = in_i.rem >= {1'b0, in_i.span};
  assign diff = ge ? (in_i.rem - {1'b0, in_i.span}) : in_i.rem;

  always_comb begin
    pay_d      = in_i;
    pay_d.rem  = {diff[RemW-2:0], 1'b0};
    pay_d.quo  = {in_i.quo[LevelW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= pay_d;
    end
  end

  always_comb begin
    out_o       = pay_q;
    out_o.valid = valid_q;
  end

endmodule

FILE: rtl/calibrated_level_scaler_unit.sv
// Top level of the calibrated level scaler: registers, front stage and divider cell row.
// The block maps each pulse count onto a level from 0 at the wet count to 1024 at the dry
// count and accepts one item per clock cycle. An item passes first through the front stage,
// which checks the calibration and clamps the count, then through each of the eleven
// division cells in turn, each of which produces one quotient bit.
// The whole row advances together, so while the output item is not taken the input side
// stalls as well. Calibration registers reset to all ones and must be written before use.
module calibrated_level_scaler_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cls_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cls_pkg::CountW-1:0]  cfg_wdata_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [31:0]                 s_axis_tdata_i,   // [31:0] pulse_count
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [15:0]                 m_axis_tdata_o,   // [10:0] level, [15:11] zero
  output logic [1:0]                  m_axis_tuser_o    // [1:0] status
);
  import cls_pkg::*;

  logic [CountW-1:0] dry_q, wet_q;
  stage_t            stg [NumCells+1];
  logic              adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_q <= ErasedValue;
      wet_q <= ErasedValue;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_DRY_COUNT: dry_q <= cfg_wdata_i;
        REG_WET_COUNT: wet_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign adv             = !stg[NumCells].valid || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  cls_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid_i),
    .count_i (s_axis_tdata_i),
    .dry_i   (dry_q),
    .wet_i   (wet_q),
    .out_o   (stg[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    cls_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .in_i   (stg[k]),
      .out_o  (stg[k+1])
    );
  end

  assign m_axis_tvalid_o = stg[NumCells].valid;
  assign m_axis_tuser_o  = stg[NumCells].status;
  assign m_axis_tdata_o  = {(16 - LevelW)'(0),
                            (stg[NumCells].status == STATUS_OK) ? stg[NumCells].quo
                                                                : LevelW'(0)};

endmodule

FILE: rtl/cls_checker.sv
// Port-level checks of the calibrated level scaler and their binding to the top level.
`include "calibrated_level_scaler_unit_assert.svh"

module cls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);
  import cls_pkg::*;

  `CLS_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
  `CLS_ASSERT_SAME(a_err_level_zero, m_axis_tvalid_o && (m_axis_tuser_o != STATUS_OK), m_axis_tdata_o == 16'd0)
  `CLS_ASSERT_SAME(a_level_range, m_axis_tvalid_o, m_axis_tdata_o <= 16'd1024)
  `CLS_ASSERT_SAME(a_status_code, m_axis_tvalid_o, (m_axis_tuser_o == STATUS_OK) || (m_axis_tuser_o == STATUS_CAL_ERR) || (m_axis_tuser_o == STATUS_SENSOR_ERR))
  `CLS_ASSERT_SAME(a_ready_follows, 1'b1, s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))

endmodule

bind calibrated_level_scaler_unit cls_checker u_cls_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
